[rtl/cas_pkg.sv]
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants for the cave smoothing block
// Field widths, register map, reset values and the result queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

  // Fixed field widths
  localparam int CAS_CELLS_W  = 64;
  localparam int CAS_LIMIT_W  = 4;
  localparam int CAS_WIDTH_W  = 7;
  localparam int CAS_COUNT_W  = 4;

  // Default row length (cells per row the hardware holds)
  localparam int CAS_MAX_ROW_CELLS = 64;

  // Result queue depth
  localparam int CAS_FIFO_DEPTH = 4;
  localparam int CAS_FIFO_PTR_W = $clog2(CAS_FIFO_DEPTH);
  localparam int CAS_FIFO_CNT_W = $clog2(CAS_FIFO_DEPTH + 1);

  // APB register map
  localparam int CAS_APB_ADDR_W = 4;
  localparam int CAS_APB_DATA_W = 32;
  localparam int CAS_REG_IDX_W  = CAS_APB_ADDR_W - 2;

  localparam logic [CAS_REG_IDX_W-1:0] REG_DEATH_LIMIT = 2'd0;
  localparam logic [CAS_REG_IDX_W-1:0] REG_BIRTH_LIMIT = 2'd1;
  localparam logic [CAS_REG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd2;

  // Register reset values
  localparam logic [CAS_LIMIT_W-1:0] DEATH_LIMIT_RST = 4'd4;
  localparam logic [CAS_LIMIT_W-1:0] BIRTH_LIMIT_RST = 4'd4;
  localparam logic [CAS_WIDTH_W-1:0] ROW_WIDTH_RST   = 7'd64;

  typedef logic [CAS_CELLS_W-1:0] cells_t;

  // Rule settings handed to the row smoother
  typedef struct packed {
    logic [CAS_LIMIT_W-1:0] death_thresh;
    logic [CAS_LIMIT_W-1:0] birth_thresh;
    logic [CAS_WIDTH_W-1:0] row_width;
  } cfg_t;

  // One result row as it sits in the queue
  typedef struct packed {
    cells_t out_cells;
    logic   frame_end;
  } result_t;

  // Push control into the result queue: second entry only with the first
  typedef struct packed {
    logic push_first;
    logic push_second;
  } push_t;

  // Frame position, one-hot
  typedef enum logic [2:0] {
    ROWS_NONE = 3'b001,
    ROWS_ONE  = 3'b010,
    ROWS_TWO  = 3'b100
  } rows_seen_e;

endpackage

`default_nettype wire

[rtl/cas_stream_if.sv]
// ----------------------------------------------------------------------------
// cas_stream_if: valid/ready channels of the cave smoothing block
// Input channel carries one grid row; output channel one result row.
// ----------------------------------------------------------------------------
`default_nettype none

interface cas_row_in_if;
  logic            valid;
  logic            ready;
  cas_pkg::cells_t row_cells;
  logic            last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface cas_row_out_if;
  logic            valid;
  logic            ready;
  cas_pkg::cells_t out_cells;
  logic            frame_end;

  modport source (output valid, output out_cells, output frame_end, input ready);
  modport sink   (input valid, input out_cells, input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/cas_lane.sv]
// ----------------------------------------------------------------------------
// cas_lane: one interior cell of the smoothing rule
// Count alive neighbours in the 3x3 window and apply death/birth limits.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_lane (
  input  wire logic [2:0]                      above_i,
  input  wire logic [2:0]                      here_i,
  input  wire logic [2:0]                      below_i,
  input  wire logic                            interior_i,
  input  wire logic [cas_pkg::CAS_LIMIT_W-1:0] death_thresh_i,
  input  wire logic [cas_pkg::CAS_LIMIT_W-1:0] birth_thresh_i,
  output logic                                 cell_o
);

  logic [cas_pkg::CAS_COUNT_W-1:0] count;

  assign count = cas_pkg::CAS_COUNT_W'(above_i[0]) + cas_pkg::CAS_COUNT_W'(above_i[1])
               + cas_pkg::CAS_COUNT_W'(above_i[2]) + cas_pkg::CAS_COUNT_W'(here_i[0])
               + cas_pkg::CAS_COUNT_W'(here_i[2])  + cas_pkg::CAS_COUNT_W'(below_i[0])
               + cas_pkg::CAS_COUNT_W'(below_i[1]) + cas_pkg::CAS_COUNT_W'(below_i[2]);

  always_comb begin
    cell_o = here_i[1];
    if (interior_i) begin
      if (here_i[1] && (count < death_thresh_i)) begin
        cell_o = 1'b0;
      end else if (count > birth_thresh_i) begin
        cell_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/cas_row_smoother.sv]
// ----------------------------------------------------------------------------
// cas_row_smoother: all lanes of one row plus the merging stage
// Mask rows to the width in use, run one lane per interior column and
// merge lane outputs with the pass-through border columns.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_row_smoother #(
  parameter int MAX_ROW_CELLS = cas_pkg::CAS_MAX_ROW_CELLS
) (
  input  wire cas_pkg::cfg_t             cfg_i,
  input  wire logic [MAX_ROW_CELLS-1:0] above_i,
  input  wire logic [MAX_ROW_CELLS-1:0] here_i,
  input  wire logic [MAX_ROW_CELLS-1:0] below_i,
  output logic      [MAX_ROW_CELLS-1:0] below_masked_o,
  output logic      [MAX_ROW_CELLS-1:0] smoothed_o
);

  localparam logic [cas_pkg::CAS_WIDTH_W-1:0] MaxWidth =
    cas_pkg::CAS_WIDTH_W'(MAX_ROW_CELLS);

  logic [cas_pkg::CAS_WIDTH_W-1:0] width_eff;
  logic [MAX_ROW_CELLS-1:0]        mask;
  logic [MAX_ROW_CELLS-1:0]        above_m;
  logic [MAX_ROW_CELLS-1:0]        here_m;
  logic [MAX_ROW_CELLS-1:0]        below_m;
  logic [MAX_ROW_CELLS-1:0]        merged;

  assign width_eff = (cfg_i.row_width > MaxWidth) ? MaxWidth : cfg_i.row_width;

  for (genvar x = 0; x < MAX_ROW_CELLS; x++) begin : g_mask
    assign mask[x] = (cas_pkg::CAS_WIDTH_W'(x) < width_eff);
  end

  assign above_m = above_i & mask;
  assign here_m  = here_i & mask;
  assign below_m = below_i & mask;

  for (genvar x = 0; x < MAX_ROW_CELLS; x++) begin : g_lane
    if (x == 0 || x == MAX_ROW_CELLS - 1) begin : g_edge
      // outer columns can never be interior
      assign merged[x] = here_m[x];
    end else begin : g_core
      logic interior;
      assign interior = (cas_pkg::CAS_WIDTH_W'(x) + cas_pkg::CAS_WIDTH_W'(1)) < width_eff;

      cas_lane u_lane (
        .above_i        (above_m[x+1:x-1]),
        .here_i         (here_m[x+1:x-1]),
        .below_i        (below_m[x+1:x-1]),
        .interior_i     (interior),
        .death_thresh_i (cfg_i.death_thresh),
        .birth_thresh_i (cfg_i.birth_thresh),
        .cell_o         (merged[x])
      );
    end
  end

  assign smoothed_o     = merged & mask;
  assign below_masked_o = below_m;

endmodule

`default_nettype wire

[rtl/cas_result_fifo.sv]
// ----------------------------------------------------------------------------
// cas_result_fifo: small result queue, two pushes and one pop per cycle
// Registered head drives the output channel directly.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_result_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cas_pkg::push_t   push_i,
  input  wire cas_pkg::result_t first_i,
  input  wire cas_pkg::result_t second_i,
  output logic                  room_for_two_o,
  output logic                  valid_o,
  output cas_pkg::result_t      head_o,
  input  wire logic             pop_i
);

  localparam int PtrW = cas_pkg::CAS_FIFO_PTR_W;
  localparam int CntW = cas_pkg::CAS_FIFO_CNT_W;

  cas_pkg::result_t mem_q [cas_pkg::CAS_FIFO_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  push_cnt;
  logic             pop;

  assign pop      = pop_i && (count_q != '0);
  assign push_cnt = CntW'(push_i.push_first) + CntW'(push_i.push_second);

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + push_cnt - CntW'(pop);

  assign room_for_two_o = (count_q <= CntW'(cas_pkg::CAS_FIFO_DEPTH - 2));
  assign valid_o        = (count_q != '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_first) begin
      mem_q[wr_ptr_q] <= first_i;
    end
    if (push_i.push_second) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= second_i;
    end
  end

endmodule

`default_nettype wire

[rtl/cave_automaton_smoothing.sv]
// ----------------------------------------------------------------------------
// cave_automaton_smoothing: one generation of cave-smoothing automaton
// Row-streamed smoothing with a two-row window, lane per column, APB setup.
// ----------------------------------------------------------------------------
// The block takes one grid row per transfer on rows_i and returns next-
// generation rows on results_o. A new row is accepted every clock cycle: all
// cells of a row are updated at once by one lane per column. Results go into a
// four-entry queue whose head is the output register; the input is held off
// only while fewer than two queue entries are free, which happens only when
// results_o is back-pressured. Row 0 of a frame comes out unchanged, row 1
// produces nothing (unless it ends the frame), each later row releases the
// smoothed row above it, and the last row also releases itself with frame_end
// set. The three rule registers (death threshold at 0x0, birth threshold at
// 0x4, row_width at 0x8) are to be written only while idle.
`default_nettype none

module cave_automaton_smoothing #(
  parameter int MAX_ROW_CELLS = cas_pkg::CAS_MAX_ROW_CELLS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  cas_row_in_if.sink                               rows_i,
  cas_row_out_if.source                            results_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cas_pkg::CAS_APB_ADDR_W-1:0] paddr,
  input  wire logic [cas_pkg::CAS_APB_DATA_W-1:0] pwdata,
  output logic      [cas_pkg::CAS_APB_DATA_W-1:0] prdata,
  output logic                                     pready
);

  localparam int IdxW = cas_pkg::CAS_REG_IDX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cas_pkg::cfg_t   cfg_q;
  logic [IdxW-1:0] reg_idx;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[cas_pkg::CAS_APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.death_thresh <= cas_pkg::DEATH_LIMIT_RST;
      cfg_q.birth_thresh <= cas_pkg::BIRTH_LIMIT_RST;
      cfg_q.row_width    <= cas_pkg::ROW_WIDTH_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        cas_pkg::REG_DEATH_LIMIT: cfg_q.death_thresh <= pwdata[cas_pkg::CAS_LIMIT_W-1:0];
        cas_pkg::REG_BIRTH_LIMIT: cfg_q.birth_thresh <= pwdata[cas_pkg::CAS_LIMIT_W-1:0];
        cas_pkg::REG_ROW_WIDTH:   cfg_q.row_width    <= pwdata[cas_pkg::CAS_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cas_pkg::REG_DEATH_LIMIT: prdata = cas_pkg::CAS_APB_DATA_W'(cfg_q.death_thresh);
      cas_pkg::REG_BIRTH_LIMIT: prdata = cas_pkg::CAS_APB_DATA_W'(cfg_q.birth_thresh);
      cas_pkg::REG_ROW_WIDTH:   prdata = cas_pkg::CAS_APB_DATA_W'(cfg_q.row_width);
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Row window: the two rows before the incoming one
  // --------------------------------------------------------------------------
  logic [MAX_ROW_CELLS-1:0] older_q;
  logic [MAX_ROW_CELLS-1:0] middle_q;
  cas_pkg::rows_seen_e      rows_seen_q, rows_seen_d;

  logic                     accept;
  logic                     last;
  logic                     room_for_two;
  logic [MAX_ROW_CELLS-1:0] row_masked;
  logic [MAX_ROW_CELLS-1:0] smoothed;

  assign rows_i.ready = room_for_two;
  assign accept       = rows_i.valid && room_for_two;
  assign last         = rows_i.last_row;

  cas_row_smoother #(
    .MAX_ROW_CELLS (MAX_ROW_CELLS)
  ) u_smoother (
    .cfg_i          (cfg_q),
    .above_i        (older_q),
    .here_i         (middle_q),
    .below_i        (rows_i.row_cells[MAX_ROW_CELLS-1:0]),
    .below_masked_o (row_masked),
    .smoothed_o     (smoothed)
  );

  // --------------------------------------------------------------------------
  // Result selection per frame position
  // --------------------------------------------------------------------------
  cas_pkg::push_t   push;
  cas_pkg::result_t first_res;
  cas_pkg::result_t second_res;

  // second result is always the last row passing through
  assign second_res.out_cells = cas_pkg::cells_t'(row_masked);
  assign second_res.frame_end = 1'b1;

  always_comb begin
    push.push_first      = 1'b0;
    push.push_second     = 1'b0;
    first_res.out_cells  = cas_pkg::cells_t'(row_masked);
    first_res.frame_end  = last;
    rows_seen_d          = rows_seen_q;
    case (rows_seen_q)
      cas_pkg::ROWS_NONE: begin
        // top border row: emit at once
        push.push_first = accept;
        rows_seen_d     = cas_pkg::ROWS_ONE;
      end
      cas_pkg::ROWS_ONE: begin
        // hold unless this row closes a two-row frame
        push.push_first = accept && last;
        rows_seen_d     = cas_pkg::ROWS_TWO;
      end
      cas_pkg::ROWS_TWO: begin
        // release the smoothed middle row, then the bottom row if last
        push.push_first     = accept;
        push.push_second    = accept && last;
        first_res.out_cells = cas_pkg::cells_t'(smoothed);
        first_res.frame_end = 1'b0;
      end
      default: begin
        rows_seen_d = cas_pkg::ROWS_NONE;
      end
    endcase
    if (last) begin
      rows_seen_d = cas_pkg::ROWS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q     <= '0;
      middle_q    <= '0;
      rows_seen_q <= cas_pkg::ROWS_NONE;
    end else if (accept) begin
      rows_seen_q <= rows_seen_d;
      if (last) begin
        // frame done: drop the window
        older_q  <= '0;
        middle_q <= '0;
      end else begin
        // advance the window by one row
        older_q  <= middle_q;
        middle_q <= row_masked;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue and output channel
  // --------------------------------------------------------------------------
  cas_pkg::result_t head;

  cas_result_fifo u_fifo (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .first_i        (first_res),
    .second_i       (second_res),
    .room_for_two_o (room_for_two),
    .valid_o        (results_o.valid),
    .head_o         (head),
    .pop_i          (results_o.ready)
  );

  assign results_o.out_cells = head.out_cells;
  assign results_o.frame_end = head.frame_end;

endmodule

`default_nettype wire
